### hdl/assert_macros.svh
// Assertion macros shared by the friction clamp RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with reset disable
`define CFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form
`define CFC_ASSERT_IMP(lbl, ante, cons, msg) \
  `CFC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### hdl/cfc_pkg.sv
// Shared types, widths and helpers for the friction clamp
`timescale 1ns / 1ps
package cfc_pkg;
  localparam int VW = 32;
  localparam int NW = 18;
  localparam int CW = 31;
  localparam int RW = 32;
  localparam int MW = 70;

  typedef logic [2:0][VW-1:0] vec3_t;

  function automatic logic [VW-1:0] sat32(input logic signed [MW-1:0] x);
    logic signed [MW-1:0] hi;
    logic signed [MW-1:0] lo;
    hi = MW'(32'sh7FFF_FFFF);
    lo = ~hi;
    if (x > hi) return 32'h7FFF_FFFF;
    else if (x < lo) return 32'h8000_0000;
    else return x[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] mag32(input logic [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : v;
  endfunction
endpackage

### hdl/cfc_isqrt.sv
// Pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
module cfc_isqrt import cfc_pkg::*; #(
  parameter int LANES = 2,
  parameter int SW = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [LANES-1:0][63:0]      rad_i,
  input  logic [SW-1:0]               side_i,
  output logic                        valid_o,
  output logic [LANES-1:0][RW-1:0]    root_o,
  output logic [SW-1:0]               side_o
);
  logic [LANES-1:0][63:0] x_q [RW];
  logic [LANES-1:0][63:0] r_q [RW];
  logic [SW-1:0]          sd_q [RW];
  logic                   v_q [RW];

  for (genvar s = 0; s < RW; s++) begin : g_st
    localparam logic [63:0] BIT = 64'd1 << (2 * (RW - 1 - s));
    logic [LANES-1:0][63:0] x_in, r_in, x_d, r_d, trial;
    logic                   v_in;
    logic [SW-1:0]          sd_in;
    if (s == 0) begin : g_first
      assign x_in  = rad_i;
      assign r_in  = '0;
      assign v_in  = valid_i;
      assign sd_in = side_i;
    end else begin : g_next
      assign x_in  = x_q[s-1];
      assign r_in  = r_q[s-1];
      assign v_in  = v_q[s-1];
      assign sd_in = sd_q[s-1];
    end
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = r_in[l] + BIT;
        if (x_in[l] >= trial[l]) begin
          x_d[l] = x_in[l] - trial[l];
          r_d[l] = (r_in[l] >> 1) + BIT;
        end else begin
          x_d[l] = x_in[l];
          r_d[l] = r_in[l] >> 1;
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[s] <= 1'b0;
      else if (en_i) v_q[s] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s]  <= x_d;
        r_q[s]  <= r_d;
        sd_q[s] <= sd_in;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) root_o[l] = r_q[RW-1][l][RW-1:0];
  end
  assign valid_o = v_q[RW-1];
  assign side_o  = sd_q[RW-1];
endmodule

### hdl/cfc_div.sv
// Pipelined restoring divider, one quotient bit per stage, shared divisor
`timescale 1ns / 1ps
module cfc_div import cfc_pkg::*; #(
  parameter int LANES = 3,
  parameter int SW = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [LANES-1:0][63:0]      num_i,
  input  logic [RW-1:0]               den_i,
  input  logic [SW-1:0]               side_i,
  output logic                        valid_o,
  output logic [LANES-1:0][RW-1:0]    quot_o,
  output logic [SW-1:0]               side_o
);
  logic [LANES-1:0][63:0]   rem_q [RW];
  logic [LANES-1:0][RW-1:0] q_q [RW];
  logic [RW-1:0]            den_q [RW];
  logic [SW-1:0]            sd_q [RW];
  logic                     v_q [RW];

  for (genvar s = 0; s < RW; s++) begin : g_st
    localparam int K = RW - 1 - s;
    logic [LANES-1:0][63:0]   rem_in, rem_d;
    logic [LANES-1:0][RW-1:0] q_in, q_d;
    logic [RW-1:0]            den_in;
    logic [63:0]              dsh;
    logic                     v_in;
    logic [SW-1:0]            sd_in;
    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign q_in   = '0;
      assign den_in = den_i;
      assign v_in   = valid_i;
      assign sd_in  = side_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign q_in   = q_q[s-1];
      assign den_in = den_q[s-1];
      assign v_in   = v_q[s-1];
      assign sd_in  = sd_q[s-1];
    end
    assign dsh = 64'(den_in) << K;
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        q_d[l] = q_in[l];
        if (rem_in[l] >= dsh) begin
          rem_d[l]  = rem_in[l] - dsh;
          q_d[l][K] = 1'b1;
        end else begin
          rem_d[l] = rem_in[l];
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[s] <= 1'b0;
      else if (en_i) v_q[s] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        q_q[s]   <= q_d;
        den_q[s] <= den_in;
        sd_q[s]  <= sd_in;
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign quot_o  = q_q[RW-1];
  assign side_o  = sd_q[RW-1];
endmodule

### hdl/coulomb_friction_clamp.sv
// Path: dot-product stages, square-root pipe, limit and clamp stages, divider pipe, output register.
// Throughput: one item per cycle; the whole pipe holds while a result waits under stall_i.
// The sqrt pipe resolves one root bit per stage and the divider one quotient bit per stage.
// Reset: rst_ni clears every stage valid bit asynchronously; payload is not reset.
// Top level: friction cone clamp pipeline
`timescale 1ns / 1ps
`include "assert_macros.svh"
module coulomb_friction_clamp import cfc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic signed [VW-1:0] force_x_i,
  input  logic signed [VW-1:0] force_y_i,
  input  logic signed [VW-1:0] force_z_i,
  input  logic signed [NW-1:0] normal_x_i,
  input  logic signed [NW-1:0] normal_y_i,
  input  logic signed [NW-1:0] normal_z_i,
  input  logic        [CW-1:0] friction_coef_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic signed [VW-1:0] normal_part_x_o,
  output logic signed [VW-1:0] normal_part_y_o,
  output logic signed [VW-1:0] normal_part_z_o,
  output logic signed [VW-1:0] friction_x_o,
  output logic signed [VW-1:0] friction_y_o,
  output logic signed [VW-1:0] friction_z_o,
  output logic                 was_clamped_o
);
  localparam logic [RW-1:0] EPS =
    RW'(((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000);
  localparam int SQ_SW = CW + 6 * VW;
  localparam int DV_SW = 2 + 6 * VW;

  logic en;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  // stage 1: dot products
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, vo_q;
  logic sq_v, dv_v;
  logic [2:0][VW-1:0] f_in;
  logic [2:0][NW-1:0] nv_in;
  logic [2:0][VW-1:0] f1_q, f2_q, f3_q;
  logic [2:0][NW-1:0] nv1_q, nv2_q;
  logic [2:0][49:0]   p1_q;
  logic [CW-1:0]      c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic signed [51:0] d2_q;
  logic [2:0][MW-1:0] m3_q;
  vec3_t n4_q, t4_q, n5_q, t5_q, n6_q, t6_q, n7_q, t7_q, n8_q, t8_q, n9_q, t9_q;
  logic [2:0][63:0]   tsq5_q, nsq5_q;
  logic [63:0]        tsum6_q, nsum6_q;

  assign f_in  = {force_z_i, force_y_i, force_x_i};
  assign nv_in = {normal_z_i, normal_y_i, normal_x_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0; v9_q <= 1'b0; vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
      v6_q <= v5_q; v7_q <= sq_v; v8_q <= v7_q; v9_q <= v8_q; vo_q <= dv_v;
    end
  end

  logic [2:0][MW-1:0] m_d;
  vec3_t n_d, t_d;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_d[i] = sat32($signed(m3_q[i]) >>> FRAC_BITS);
      t_d[i] = sat32(MW'($signed(f3_q[i])) - MW'($signed(n_d[i])));
      m_d[i] = MW'(d2_q) * MW'($signed(nv2_q[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_q[i]   <= 50'($signed(f_in[i])) * 50'($signed(nv_in[i]));
        tsq5_q[i] <= 64'(mag32(t4_q[i])) * 64'(mag32(t4_q[i]));
        nsq5_q[i] <= 64'(mag32(n4_q[i])) * 64'(mag32(n4_q[i]));
      end
      f1_q <= f_in; nv1_q <= nv_in; c1_q <= friction_coef_i;
      d2_q <= (52'($signed(p1_q[0])) + 52'($signed(p1_q[1])) + 52'($signed(p1_q[2])))
              >>> FRAC_BITS;
      f2_q <= f1_q; nv2_q <= nv1_q; c2_q <= c1_q;
      m3_q <= m_d; f3_q <= f2_q; c3_q <= c2_q;
      n4_q <= n_d; t4_q <= t_d; c4_q <= c3_q;
      n5_q <= n4_q; t5_q <= t4_q; c5_q <= c4_q;
      tsum6_q <= tsq5_q[0] + tsq5_q[1] + tsq5_q[2];
      nsum6_q <= nsq5_q[0] + nsq5_q[1] + nsq5_q[2];
      n6_q <= n5_q; t6_q <= t5_q; c6_q <= c5_q;
    end
  end

  // square roots of |t|^2 and |n|^2
  logic [1:0][RW-1:0] sq_root;
  logic [SQ_SW-1:0]  sq_side;
  cfc_isqrt #(.LANES(2), .SW(SQ_SW)) u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6_q),
    .rad_i({nsum6_q, tsum6_q}), .side_i({c6_q, n6_q, t6_q}),
    .valid_o(sq_v), .root_o(sq_root), .side_o(sq_side)
  );

  logic [RW-1:0] tlen7_q, tlen8_q, tlen9_q, lim8_q;
  logic [62:0]   limp7_q, lim_w;
  logic          tiny8_q, clamp8_q, tiny9_q, clamp9_q;
  logic [2:0][VW-1:0] tm8_q;
  logic [2:0][63:0]   num9_q;

  assign lim_w = limp7_q >> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t7_q    <= sq_side[3*VW-1:0];
      n7_q    <= sq_side[6*VW-1:3*VW];
      tlen7_q <= sq_root[0];
      limp7_q <= 63'(sq_side[SQ_SW-1:6*VW]) * 63'(sq_root[1]);
      n8_q <= n7_q; t8_q <= t7_q; tlen8_q <= tlen7_q;
      lim8_q   <= lim_w[RW-1:0];
      tiny8_q  <= tlen7_q <= EPS;
      clamp8_q <= (tlen7_q > EPS) && (63'(tlen7_q) > lim_w);
      for (int i = 0; i < 3; i++) begin
        tm8_q[i]  <= mag32(t7_q[i]);
        num9_q[i] <= clamp8_q ? 64'(tm8_q[i]) * 64'(lim8_q) : 64'd0;
      end
      n9_q <= n8_q; t9_q <= t8_q; tlen9_q <= tlen8_q;
      tiny9_q <= tiny8_q; clamp9_q <= clamp8_q;
    end
  end

  // scale t by lim / |t|
  logic [2:0][RW-1:0] dv_q;
  logic [DV_SW-1:0]   dv_side;
  logic               dv_tiny, dv_clamp;
  vec3_t              dv_n, dv_t, fr_d;
  cfc_div #(.LANES(3), .SW(DV_SW)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v9_q),
    .num_i(num9_q), .den_i(tlen9_q), .side_i({tiny9_q, clamp9_q, n9_q, t9_q}),
    .valid_o(dv_v), .quot_o(dv_q), .side_o(dv_side)
  );
  assign dv_t     = dv_side[3*VW-1:0];
  assign dv_n     = dv_side[6*VW-1:3*VW];
  assign dv_clamp = dv_side[6*VW];
  assign dv_tiny  = dv_side[6*VW+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_tiny) fr_d[i] = '0;
      else if (dv_clamp) fr_d[i] = dv_t[i][VW-1] ? VW'(-dv_q[i]) : dv_q[i];
      else fr_d[i] = dv_t[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      normal_part_x_o <= dv_n[0];
      normal_part_y_o <= dv_n[1];
      normal_part_z_o <= dv_n[2];
      friction_x_o    <= fr_d[0];
      friction_y_o    <= fr_d[1];
      friction_z_o    <= fr_d[2];
      was_clamped_o   <= dv_clamp;
    end
  end
  assign valid_o = vo_q;

  `CFC_ASSERT_IMP(a_qx_bound, dv_v && dv_clamp, dv_q[0] <= mag32(dv_t[0]), "x quotient too big")
  `CFC_ASSERT_IMP(a_qy_bound, dv_v && dv_clamp, dv_q[1] <= mag32(dv_t[1]), "y quotient too big")
  `CFC_ASSERT_IMP(a_qz_bound, dv_v && dv_clamp, dv_q[2] <= mag32(dv_t[2]), "z quotient too big")
endmodule
